[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the word-bounded pattern counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wbpc_pkg.sv]
// Package with constants, register layout and the separator test of the pattern counter.
`default_nettype none
package wbpc_pkg;

	localparam int NUM_PATTERNS_DEF    = 4;
	localparam int MAX_PATTERN_LEN_DEF = 4;
	localparam int COUNT_WIDTH_DEF     = 32;

	// Layout of one pattern register.
	localparam int CFG_W          = 37;
	localparam int CHARS_IN_REG   = 4;
	localparam int LEN_LSB        = 32;
	localparam int LEN_W          = 3;
	localparam int LEFT_FREE_BIT  = 35;
	localparam int RIGHT_FREE_BIT = 36;

	// Separator byte ranges.
	localparam logic [7:0] SEP_CTRL_HI  = 8'h22;
	localparam logic [7:0] SEP_QUOTE_LO = 8'h27;
	localparam logic [7:0] SEP_QUOTE_HI = 8'h29;
	localparam logic [7:0] SEP_PUNCT_LO = 8'h2C;
	localparam logic [7:0] SEP_PUNCT_HI = 8'h2E;
	localparam logic [7:0] SEP_COLON    = 8'h3A;
	localparam logic [7:0] SEP_SEMI     = 8'h3B;
	localparam logic [7:0] SEP_QMARK    = 8'h3F;
	localparam logic [7:0] SEP_BQUOTE   = 8'h60;

	function automatic logic is_sep(input logic [7:0] b);
		logic r;
		r = (b <= SEP_CTRL_HI)
			|| (b >= SEP_QUOTE_LO && b <= SEP_QUOTE_HI)
			|| (b >= SEP_PUNCT_LO && b <= SEP_PUNCT_HI)
			|| (b == SEP_COLON) || (b == SEP_SEMI)
			|| (b == SEP_QMARK) || (b == SEP_BQUOTE);
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/wbpc_slot.sv]
// Match test and saturating count update for one pattern slot.
`default_nettype none
module wbpc_slot #(
	parameter int MAX_PATTERN_LEN = wbpc_pkg::MAX_PATTERN_LEN_DEF,
	parameter int COUNT_WIDTH     = wbpc_pkg::COUNT_WIDTH_DEF,
	localparam int HIST_DEPTH     = MAX_PATTERN_LEN + 1,
	localparam int SEEN_W         = $clog2(MAX_PATTERN_LEN + 3)
) (
	input  wire logic [wbpc_pkg::CFG_W-1:0] pattern,
	input  wire logic [HIST_DEPTH:0][7:0]   window,   // [0] is the current byte
	input  wire logic [SEEN_W-1:0]          seen,
	input  wire logic                       last,
	input  wire logic [COUNT_WIDTH-1:0]     cnt,
	output logic      [COUNT_WIDTH-1:0]     cnt_next
);
	import wbpc_pkg::*;

	localparam int LEN_LIM = (MAX_PATTERN_LEN < CHARS_IN_REG) ? MAX_PATTERN_LEN : CHARS_IN_REG;
	localparam int CMP_W   = SEEN_W + 1;

	logic [LEN_W-1:0]       raw_len;
	logic [LEN_W-1:0]       eff_len;
	logic                   left_free;
	logic                   right_free;
	logic                   body_prev;
	logic                   body_cur;
	logic                   lsep_prev;
	logic                   lsep_cur;
	logic                   all_prev;
	logic                   all_cur;
	logic [CMP_W-1:0]       seen_x;
	logic [CMP_W-1:0]       seen_p1;
	logic [CMP_W-1:0]       len_x;
	logic                   hit_prev;
	logic                   hit_cur;
	logic [1:0]             inc;
	logic [COUNT_WIDTH:0]   sum;

	assign raw_len    = pattern[LEN_LSB +: LEN_W];
	assign eff_len    = (raw_len > LEN_W'(LEN_LIM)) ? '0 : raw_len;
	assign left_free  = pattern[LEFT_FREE_BIT];
	assign right_free = pattern[RIGHT_FREE_BIT];

	// For each possible length, compare the window at constant offsets and
	// pick the result of the configured length.
	always_comb begin
		body_prev = 1'b0;
		body_cur  = 1'b0;
		lsep_prev = 1'b0;
		lsep_cur  = 1'b0;
		for (int l = 1; l <= LEN_LIM; l++) begin
			all_prev = 1'b1;
			all_cur  = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (window[l - i] != pattern[8*i +: 8]) all_prev = 1'b0;
				if (window[l - 1 - i] != pattern[8*i +: 8]) all_cur = 1'b0;
			end
			if (eff_len == LEN_W'(l)) begin
				body_prev = all_prev;
				body_cur  = all_cur;
				lsep_prev = is_sep(window[l + 1]);
				lsep_cur  = is_sep(window[l]);
			end
		end
	end

	assign seen_x  = CMP_W'(seen);
	assign seen_p1 = seen_x + CMP_W'(1);
	assign len_x   = CMP_W'(eff_len);

	// A match ending on the previous byte uses the current byte as its right side.
	assign hit_prev = (eff_len != '0) && (seen_x >= len_x) && body_prev
		&& (left_free || seen_x == len_x || lsep_prev)
		&& (right_free || is_sep(window[0]));

	// On the final byte, a match ending here has the buffer end on its right.
	assign hit_cur = (eff_len != '0) && last && (seen_p1 >= len_x) && body_cur
		&& (left_free || seen_p1 == len_x || lsep_cur);

	assign inc = {1'b0, hit_prev} + {1'b0, hit_cur};
	assign sum = {1'b0, cnt} + (COUNT_WIDTH + 1)'(inc);

	// Any carry out means the count passed all ones.
	assign cnt_next = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

endmodule
`default_nettype wire

[rtl/word_bounded_pattern_counter.sv]
// Top level of the word-bounded multi-pattern counter.
//
//   channel | direction | payload
//   s_axis  | in        | tdata[7:0] data_byte, tlast last_byte
//   m_axis  | out       | tdata[1:0] pattern_slot, tdata[33:2] match_count, tlast last_result
//   cfg     | in        | cfg_index selects pattern_N, cfg_data[36:0] its value
//
// Each byte waits in the input register and is folded from there into the window and
// the counters, so one byte is taken in every cycle while the input is not stalled.
// On the final byte of a buffer the counts move into an output bank that drains one
// result per transaction; the next buffer flows in meanwhile, and only its final
// byte waits while the bank still holds results.
// Reset clears the window, the counters, the pattern registers and all valid flags.
`default_nettype none
module word_bounded_pattern_counter #(
	parameter int NUM_PATTERNS    = wbpc_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_PATTERN_LEN = wbpc_pkg::MAX_PATTERN_LEN_DEF,
	parameter int COUNT_WIDTH     = wbpc_pkg::COUNT_WIDTH_DEF,
	localparam int SLOT_W         = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1,
	localparam int OUT_W          = ((SLOT_W + COUNT_WIDTH + 7) / 8) * 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,   // [7:0] data_byte
	input  wire logic                       s_tlast,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [OUT_W-1:0]           m_tdata,   // pattern_slot, match_count, zero fill
	output logic                            m_tlast,
	input  wire logic                       cfg_we,
	input  wire logic [SLOT_W-1:0]          cfg_index,
	input  wire logic [wbpc_pkg::CFG_W-1:0] cfg_data
);
	import wbpc_pkg::*;

	localparam int HIST_DEPTH = MAX_PATTERN_LEN + 1;
	localparam int SEEN_CAP   = MAX_PATTERN_LEN + 2;
	localparam int SEEN_W     = $clog2(MAX_PATTERN_LEN + 3);

	logic [CFG_W-1:0]                         pattern_q [NUM_PATTERNS];
	logic                                     valid_s1;
	logic [7:0]                               data_s1;
	logic                                     last_s1;
	logic [HIST_DEPTH-1:0][7:0]               hist_q;
	logic [SEEN_W-1:0]                        seen_q;
	logic [COUNT_WIDTH-1:0]                   cnt_q     [NUM_PATTERNS];
	logic [COUNT_WIDTH-1:0]                   cnt_next  [NUM_PATTERNS];
	logic [COUNT_WIDTH-1:0]                   bank_q    [NUM_PATTERNS];
	logic                                     bank_valid_q;
	logic [SLOT_W-1:0]                        slot_q;
	logic [HIST_DEPTH:0][7:0]                 window;
	logic                                     adv;
	logic                                     pop;
	logic                                     bank_done;

	assign window = {hist_q, data_s1};

	assign pop       = bank_valid_q && m_tready;
	assign bank_done = pop && (slot_q == SLOT_W'(NUM_PATTERNS - 1));
	assign adv       = valid_s1 && (!last_s1 || !bank_valid_q || bank_done);
	assign s_tready  = !valid_s1 || adv;

	assign m_tvalid = bank_valid_q;
	assign m_tdata  = OUT_W'({bank_q[0], slot_q});
	assign m_tlast  = (slot_q == SLOT_W'(NUM_PATTERNS - 1));

	for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_slot
		wbpc_slot #(
			.MAX_PATTERN_LEN(MAX_PATTERN_LEN),
			.COUNT_WIDTH    (COUNT_WIDTH)
		) u_slot (
			.pattern (pattern_q[k]),
			.window  (window),
			.seen    (seen_q),
			.last    (last_s1),
			.cnt     (cnt_q[k]),
			.cnt_next(cnt_next[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PATTERNS; k++) pattern_q[k] <= '0;
		end else if (cfg_we) begin
			for (int k = 0; k < NUM_PATTERNS; k++) begin
				if (cfg_index == SLOT_W'(k)) pattern_q[k] <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			data_s1  <= '0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			last_s1  <= s_tlast;
			data_s1  <= s_tdata;
		end
	end

	// Window, fill count and counters; the final byte clears them for the next buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			seen_q <= '0;
			for (int k = 0; k < NUM_PATTERNS; k++) cnt_q[k] <= '0;
		end else if (adv) begin
			if (last_s1) begin
				hist_q <= '0;
				seen_q <= '0;
				for (int k = 0; k < NUM_PATTERNS; k++) cnt_q[k] <= '0;
			end else begin
				hist_q <= {hist_q[HIST_DEPTH-2:0], data_s1};
				if (seen_q < SEEN_W'(SEEN_CAP)) seen_q <= seen_q + SEEN_W'(1);
				for (int k = 0; k < NUM_PATTERNS; k++) cnt_q[k] <= cnt_next[k];
			end
		end
	end

	// Output bank: loaded on the final byte, shifted down once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_valid_q <= 1'b0;
			slot_q       <= '0;
		end else if (adv && last_s1) begin
			bank_valid_q <= 1'b1;
			slot_q       <= '0;
		end else if (pop) begin
			if (bank_done) begin
				bank_valid_q <= 1'b0;
				slot_q       <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			for (int k = 0; k < NUM_PATTERNS; k++) bank_q[k] <= cnt_next[k];
		end else if (pop) begin
			for (int k = 0; k < NUM_PATTERNS - 1; k++) bank_q[k] <= bank_q[k + 1];
		end
	end

`include "assert_macros.svh"

	`ASSERT_NEXT(a_bank_load, adv && last_s1, m_tvalid && slot_q == '0, "bank not loaded on final byte")
	`ASSERT_NEXT(a_seen_clear, adv && last_s1, seen_q == '0 && hist_q == '0, "window not cleared")
	`ASSERT_NEXT(a_bank_drain, bank_done && !(adv && last_s1), !m_tvalid, "bank still valid after drain")

endmodule
`default_nettype wire

[tb/word_bounded_pattern_counter_tb.sv]
// Self-checking testbench for the word-bounded multi-pattern counter.
module word_bounded_pattern_counter_tb;

	localparam int SLOTS    = wbpc_pkg::NUM_PATTERNS_DEF;
	localparam int MAXLEN   = wbpc_pkg::MAX_PATTERN_LEN_DEF;
	localparam int CNT_W    = wbpc_pkg::COUNT_WIDTH_DEF;
	localparam int SLOT_W   = 2;
	localparam int OUT_W    = ((SLOT_W + CNT_W + 7) / 8) * 8;
	localparam int HIST     = MAXLEN + 1;
	localparam int SEEN_CAP = MAXLEN + 2;
	localparam int PATTERN_REG_BASE = 0;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
		logic              last;
	} slot_count_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [7:0]                s_tdata;   // [7:0] data_byte
	logic                      s_tlast;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_W-1:0]          m_tdata;   // [1:0] pattern_slot, [33:2] match_count, zero fill
	logic                      m_tlast;
	logic                      cfg_we;
	logic [SLOT_W-1:0]         cfg_index;
	logic [wbpc_pkg::CFG_W-1:0] cfg_data;

	// Shadow of the block: pattern registers, byte window and running counts.
	logic [wbpc_pkg::CFG_W-1:0] pats [SLOTS];
	logic [7:0]                 history [HIST];
	int                         seen;
	logic [CNT_W-1:0]           counts [SLOTS];

	slot_count_t pending_counts [$];
	logic [7:0]  text_q [$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	logic        quiet_run = 1'b0;
	logic        hold_request = 1'b0;

	word_bounded_pattern_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Colon, semicolon, question mark and backquote close the list of separators.
	function automatic logic is_separator(logic [7:0] b);
		return (b <= 8'h22) || (b >= 8'h27 && b <= 8'h29) || (b >= 8'h2C && b <= 8'h2E)
			|| b == 8'h3A || b == 8'h3B || b == 8'h3F || b == 8'h60;
	endfunction

	function automatic logic [7:0] window_byte(logic [7:0] cur, int d);
		if (d == 0) return cur;
		if (d <= HIST) return history[d-1];
		return 8'h00;
	endfunction

	// Pattern k sits in the window with its last byte at offset base back from cur.
	function automatic logic pattern_hit(int k, int len, logic [7:0] cur, int base);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < len; i++) begin
			if (window_byte(cur, base + len - 1 - i) != pats[k][8*i +: 8]) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic void bump_count(int k);
		if (counts[k] != '1) counts[k] = counts[k] + 1'b1;
	endfunction

	function automatic void fold_byte(logic [7:0] cur, logic lst);
		int len;
		logic lfree, rfree, lok;
		slot_count_t res;
		for (int k = 0; k < SLOTS; k++) begin
			len = int'(pats[k][wbpc_pkg::LEN_LSB +: wbpc_pkg::LEN_W]);
			if (len > MAXLEN || len > wbpc_pkg::CHARS_IN_REG) len = 0;
			lfree = pats[k][wbpc_pkg::LEFT_FREE_BIT];
			rfree = pats[k][wbpc_pkg::RIGHT_FREE_BIT];
			if (len != 0) begin
				// A match that ended on the previous byte has cur as its right neighbor.
				if (seen >= len && pattern_hit(k, len, cur, 1)) begin
					lok = lfree || seen == len || is_separator(window_byte(cur, len + 1));
					if (lok && (rfree || is_separator(cur))) bump_count(k);
				end
				// On the final byte the buffer end is a boundary on the right.
				if (lst && seen + 1 >= len && pattern_hit(k, len, cur, 0)) begin
					lok = lfree || seen + 1 == len || is_separator(window_byte(cur, len));
					if (lok) bump_count(k);
				end
			end
		end
		for (int j = HIST - 1; j > 0; j--) history[j] = history[j-1];
		history[0] = cur;
		if (seen < SEEN_CAP) seen++;
		if (lst) begin
			for (int k = 0; k < SLOTS; k++) begin
				res.slot = SLOT_W'(k);
				res.count = counts[k];
				res.last = (k == SLOTS - 1);
				pending_counts.push_back(res);
				counts[k] = '0;
			end
			for (int j = 0; j < HIST; j++) history[j] = 8'h00;
			seen = 0;
		end
	endfunction

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(5))
			0: return 8'h20;
			1: return 8'h2E;
			2: return 8'h00;
			3: return 8'h3F;
			4: return 8'h60;
			default: return 8'h28;
		endcase
	endfunction

	function automatic logic [wbpc_pkg::CFG_W-1:0] random_pattern();
		logic [wbpc_pkg::CFG_W-1:0] p;
		int r;
		for (int i = 0; i < wbpc_pkg::CHARS_IN_REG; i++) begin
			r = $urandom_range(99);
			if (r < 55) p[8*i +: 8] = 8'h61 + 8'($urandom_range(3));
			else if (r < 75) p[8*i +: 8] = pick_separator();
			else p[8*i +: 8] = 8'($urandom_range(255));
		end
		r = $urandom_range(99);
		if (r < 6) p[wbpc_pkg::LEN_LSB +: wbpc_pkg::LEN_W] = '0;
		else if (r < 12) p[wbpc_pkg::LEN_LSB +: wbpc_pkg::LEN_W] = 3'($urandom_range(7, 5));
		else p[wbpc_pkg::LEN_LSB +: wbpc_pkg::LEN_W] = 3'($urandom_range(4, 1));
		p[wbpc_pkg::LEFT_FREE_BIT] = 1'($urandom_range(1));
		p[wbpc_pkg::RIGHT_FREE_BIT] = 1'($urandom_range(1));
		return p;
	endfunction

	// Valid is never lowered and raised in one step: a gap lowers it and a later step raises it.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (!quiet_run && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		fold_byte(b, lst);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	// Whole pattern copies mixed with separators and other bytes, so the boundary logic gets exercised.
	task send_text_buffer(input int target);
		int k, len, sel;
		text_q.delete();
		while (text_q.size() < target) begin
			sel = $urandom_range(99);
			k = $urandom_range(SLOTS - 1);
			len = int'(pats[k][wbpc_pkg::LEN_LSB +: wbpc_pkg::LEN_W]);
			if (len > wbpc_pkg::CHARS_IN_REG) len = wbpc_pkg::CHARS_IN_REG;
			if (sel < 40) begin
				for (int i = 0; i < len; i++) text_q.push_back(pats[k][8*i +: 8]);
			end else if (sel < 65) begin
				text_q.push_back(pick_separator());
			end else if (sel < 80) begin
				text_q.push_back(8'h61 + 8'($urandom_range(3)));
			end else begin
				text_q.push_back(8'($urandom_range(255)));
			end
		end
		for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	// Wait for every count, then let the input register and output bank go quiet.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_patterns(input logic [wbpc_pkg::CFG_W-1:0] p0, p1, p2, p3);
		logic [wbpc_pkg::CFG_W-1:0] vals [SLOTS];
		vals = '{p0, p1, p2, p3};
		for (int k = 0; k < SLOTS; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= SLOT_W'(PATTERN_REG_BASE + k);
			cfg_data <= vals[k];
			@(posedge clk);
			pats[k] = vals[k];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		// "the" with both boundaries, "a" left free, a binary run both free, length five off.
		load_patterns({2'b00, 3'd3, 8'hA5, "eht"}, {1'b0, 1'b1, 3'd1, 24'hFFFFFF, "a"},
			{1'b1, 1'b1, 3'd4, 32'h7F0080FF}, {2'b11, 3'd5, "aaaa"});
		send_text("the thea");
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_text("the");
		send_text("a");
		send_byte(8'h00, 1'b1);
		send_text(",the");
		settle_block();
	endtask

	task automatic test_extreme_patterns();
		int start, n, r;
		load_patterns('0, '1, {2'b11, 3'd4, 32'hFFFF_FFFF}, {2'b00, 3'd1, 32'h0});
		start = bytes_sent;
		while (bytes_sent - start < 50) begin
			n = $urandom_range(8, 1);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(99);
				send_byte(r < 40 ? 8'hFF : r < 70 ? 8'h00 : 8'($urandom_range(255)), i == n - 1);
			end
		end
		settle_block();
	endtask

	task automatic test_random_phases();
		int start;
		for (int ph = 0; ph < 4; ph++) begin
			load_patterns(random_pattern(), random_pattern(), random_pattern(), random_pattern());
			start = bytes_sent;
			while (bytes_sent - start < 60) send_text_buffer($urandom_range(14, 1));
			settle_block();
		end
	endtask

	// Short buffers while the receiver stalls fill the output bank and stop the input.
	task automatic test_back_pressure();
		int start;
		load_patterns(random_pattern(), random_pattern(), random_pattern(), random_pattern());
		hold_request = 1'b1;
		wait (!hold_request);
		start = bytes_sent;
		while (bytes_sent - start < 40) send_text_buffer($urandom_range(3, 1));
		settle_block();
	endtask

	task automatic test_full_rate();
		int start;
		load_patterns(random_pattern(), random_pattern(), random_pattern(), random_pattern());
		quiet_run = 1'b1;
		start = bytes_sent;
		while (bytes_sent - start < 60) send_text_buffer($urandom_range(16, 2));
		settle_block();
		quiet_run = 1'b0;
	endtask

	initial begin : result_sink
		int hold_left;
		logic rdy;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (!arst_n || hold_left > 0) rdy = 1'b0;
			else rdy = quiet_run || ($urandom_range(99) >= 24);
			if (hold_left > 0) hold_left--;
			m_tready <= rdy;
		end
	end

	// Outputs are sampled mid-cycle; a transaction seen here completes at the next rising edge.
	always @(negedge clk) begin : count_monitor
		slot_count_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_counts.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected count: slot %0d count %0d last %0b",
						m_tdata[1:0], m_tdata[33:2], m_tlast);
				mismatches++;
			end else begin
				want = pending_counts.pop_front();
				if (m_tdata[1:0] !== want.slot || m_tdata[33:2] !== want.count
						|| m_tlast !== want.last) begin
					if (mismatches < 10)
						$display("count mismatch: expected slot %0d count %0d last %0b, %s",
							want.slot, want.count, want.last,
							$sformatf("got slot %0d count %0d last %0b",
								m_tdata[1:0], m_tdata[33:2], m_tlast));
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		for (int k = 0; k < SLOTS; k++) begin
			pats[k] = '0;
			counts[k] = '0;
		end
		for (int j = 0; j < HIST; j++) history[j] = 8'h00;
		seen = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_patterns();
		test_random_phases();
		test_back_pressure();
		test_full_rate();
		if (pending_counts.size() != 0) begin
			$display("%0d expected counts never arrived", pending_counts.size());
			mismatches++;
		end
		if (mismatches == 0) $display("[word_bounded_pattern_counter] OK");
		else $display("[word_bounded_pattern_counter] ERROR");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("[word_bounded_pattern_counter] ERROR");
		$finish;
	end

endmodule

[word_bounded_pattern_counter.f]
+incdir+rtl
rtl/wbpc_pkg.sv
rtl/wbpc_slot.sv
rtl/word_bounded_pattern_counter.sv
tb/word_bounded_pattern_counter_tb.sv
